// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent assertions with active-low reset masking
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication whose consequent is checked in the next cycle, outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: hw/rtl/tlbsc_pkg.sv
// ----------------------------------------------------------------------------
// tlbsc_pkg
// shared constants and chain types of the second-chance tlb
// ----------------------------------------------------------------------------
`default_nettype none

package tlbsc_pkg;

    localparam int INDEX_BITS  = 4;
    localparam int ENTRIES     = 1 << INDEX_BITS;
    localparam int VPN_BITS    = 20;
    localparam int PFN_BITS    = 16;
    localparam int OFF_BITS    = 16;
    localparam int ADDR_BITS   = 32;
    localparam int SHIFT_BITS  = 5;
    localparam logic [SHIFT_BITS-1:0] SHIFT_RESET = SHIFT_BITS'(12);

    localparam int IN_FIELD_BITS  = VPN_BITS + OFF_BITS + PFN_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = ADDR_BITS + 3 + VPN_BITS;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // request broadcast to every cell
    typedef struct packed {
        logic                step;
        logic                wr;
        logic [VPN_BITS-1:0] vpn;
        logic [PFN_BITS-1:0] walk;
    } t_req;

    // priority flags: seen in some cell to the left (or anywhere, at row end)
    typedef struct packed {
        logic hit;
        logic free;
        logic clr;
    } t_seek;

    // data collected along the row
    typedef struct packed {
        logic [PFN_BITS-1:0] frame;
        logic                ev_dirty;
        logic [VPN_BITS-1:0] ev_page;
    } t_data;

endpackage

`default_nettype wire

// File: hw/rtl/tlbsc_cell.sv
// ----------------------------------------------------------------------------
// tlbsc_cell
// one tlb entry: tag compare, priority flags and second-chance marks
// ----------------------------------------------------------------------------
`default_nettype none

module tlbsc_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_first,
    input  wire tlbsc_pkg::t_req  i_req,
    input  wire tlbsc_pkg::t_seek i_seek,
    output tlbsc_pkg::t_seek      o_seek,
    input  wire tlbsc_pkg::t_seek i_glob,
    input  wire tlbsc_pkg::t_data i_data,
    output tlbsc_pkg::t_data      o_data
);
    import tlbsc_pkg::*;

    logic                r_valid;
    logic                r_used;
    logic                r_dirty;
    logic [VPN_BITS-1:0] r_page;
    logic [PFN_BITS-1:0] r_frame;

    logic match;
    logic hit_here;
    logic free_here;
    logic clr_here;
    logic victim;

    assign match     = r_valid && (r_page == i_req.vpn);
    assign hit_here  = match && !i_seek.hit;
    assign free_here = !r_valid && !i_seek.free;
    assign clr_here  = r_valid && !r_used && !i_seek.clr;

    assign o_seek.hit  = i_seek.hit  || match;
    assign o_seek.free = i_seek.free || !r_valid;
    assign o_seek.clr  = i_seek.clr  || (r_valid && !r_used);

    // victim choice: none on a hit, else first free entry, else first clear used mark, else entry 0
    always_comb begin
        if (i_glob.hit) begin
            victim = 1'b0;
        end else if (i_glob.free) begin
            victim = free_here;
        end else if (i_glob.clr) begin
            victim = clr_here;
        end else begin
            victim = i_first;
        end
    end

    always_comb begin
        o_data = i_data;
        if (hit_here) begin
            o_data.frame = r_frame;
        end
        if (victim && r_valid && r_dirty) begin
            o_data.ev_dirty = 1'b1;
            o_data.ev_page  = r_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_used  <= 1'b0;
            r_dirty <= 1'b0;
        end else if (i_req.step) begin
            if (hit_here) begin
                r_used <= 1'b1;
                if (i_req.wr) begin
                    r_dirty <= 1'b1;
                end
            end else if (victim) begin
                r_valid <= 1'b1;
                r_used  <= 1'b1;
                r_dirty <= i_req.wr;
            end else if (!i_glob.hit && !i_glob.free && !i_seek.clr) begin
                // sweep passes over this entry: second chance used up
                r_used <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.step && victim) begin
            r_page  <= i_req.vpn;
            r_frame <= i_req.walk;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tlb_lookup_second_chance.sv
// ----------------------------------------------------------------------------
// tlb_lookup_second_chance
// fully associative tlb with second-chance (clock) replacement
// ----------------------------------------------------------------------------
// every access is first captured in the input register; then, once the
// output register is free, the row of entry cells compares the page, resolves
// the hit, free-entry and clear-mark priorities by rippling flags from entry 0
// upward, updates the marks and loads the output register. the ripple across
// the row of cells is the critical path. a new access is taken once the
// previous one has moved into the output register, so while a result waits on
// m_axis_tready the next access is already captured. on a hit the entry's used
// mark is set (and dirty on a write); on a miss the lowest invalid entry is
// filled, else a sweep from entry 0 clears used marks up to the first entry
// with a clear mark, which is replaced (entry 0 if all marks were set). a dirty
// victim reports its page. page_shift is written through i_cfg_we/i_cfg_wdata
// by the user only while the block is idle, unenforced by it; it resets to 12.
// ----------------------------------------------------------------------------
`default_nettype none

module tlb_lookup_second_chance (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    // configuration: page_shift
    input  wire                                   i_cfg_we,
    input  wire  [tlbsc_pkg::SHIFT_BITS-1:0]      i_cfg_wdata,
    // access in
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    // tdata, low bit up: virt_page, page_offset, walk_frame, zero fill
    input  wire  [tlbsc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
    // tuser: is_write
    input  wire                                   s_axis_tuser,
    // result out
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    // tdata, low bit up: phys_addr, hit, mark_page_dirty, evict_dirty,
    // evicted_page, zero fill
    output logic [tlbsc_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata
);
    import tlbsc_pkg::*;

    `include "assert_macros.svh"

    logic [SHIFT_BITS-1:0] r_page_shift;

    // captured access
    logic                r_busy;
    logic [VPN_BITS-1:0] r_vpn;
    logic [OFF_BITS-1:0] r_off;
    logic                r_wr;
    logic [PFN_BITS-1:0] r_walk;

    // result register
    logic                      r_out_valid;
    logic [OUT_TDATA_BITS-1:0] r_out_data;

    logic  step;
    t_req  req;
    t_seek seek [ENTRIES+1];
    t_data data [ENTRIES+1];
    t_seek glob;

    logic [PFN_BITS-1:0]  frame;
    logic [ADDR_BITS-1:0] frame_shl;
    logic [ADDR_BITS-1:0] off_mask;
    logic [ADDR_BITS-1:0] phys;

    assign s_axis_tready = !r_busy;
    assign step          = r_busy && (!r_out_valid || m_axis_tready);

    assign req.step = step;
    assign req.wr   = r_wr;
    assign req.vpn  = r_vpn;
    assign req.walk = r_walk;

    // row inputs: nothing seen yet, nothing collected
    assign seek[0] = '0;
    assign data[0] = '0;
    assign glob    = seek[ENTRIES];

    for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
        tlbsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_first (1'(gi == 0)),
            .i_req   (req),
            .i_seek  (seek[gi]),
            .o_seek  (seek[gi+1]),
            .i_glob  (glob),
            .i_data  (data[gi]),
            .o_data  (data[gi+1])
        );
    end

    // hit frame from the matching cell, else the walked frame
    assign frame     = glob.hit ? data[ENTRIES].frame : r_walk;
    // address keeps its low 32 bits, so the shift is done at that width
    assign frame_shl = ADDR_BITS'(frame) << r_page_shift;
    assign off_mask  = (ADDR_BITS'(1) << r_page_shift) - ADDR_BITS'(1);
    assign phys      = frame_shl | (ADDR_BITS'(r_off) & off_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= SHIFT_RESET;
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_page_shift <= i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_busy <= 1'b1;
            end else if (step) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_vpn  <= s_axis_tdata[VPN_BITS-1:0];
            r_off  <= s_axis_tdata[VPN_BITS +: OFF_BITS];
            r_walk <= s_axis_tdata[VPN_BITS+OFF_BITS +: PFN_BITS];
            r_wr   <= s_axis_tuser;
        end
        if (step) begin
            r_out_data <= OUT_TDATA_BITS'({
                (glob.hit ? VPN_BITS'(0) : data[ENTRIES].ev_page),
                (!glob.hit && data[ENTRIES].ev_dirty),
                (glob.hit && r_wr),
                glob.hit,
                phys});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a hit never evicts, and a dirty mark request only comes with a hit
    `ASSERT_CLK(a_hit_no_evict, i_clk, i_rst_n,
        !(m_axis_tvalid && m_axis_tdata[ADDR_BITS] && m_axis_tdata[ADDR_BITS+2]),
        "hit together with eviction")
    `ASSERT_CLK(a_dirty_needs_hit, i_clk, i_rst_n,
        !(m_axis_tvalid && m_axis_tdata[ADDR_BITS+1] && !m_axis_tdata[ADDR_BITS]),
        "dirty mark request without hit")
    // a processed access frees the input register in the next cycle
    `ASSERT_NEXT(a_step_frees, i_clk, i_rst_n, step, !r_busy && r_out_valid,
        "access not retired after lookup")

endmodule

`default_nettype wire

// File: sim/tb_tlb_lookup_second_chance.sv
// ----------------------------------------------------------------------------
// tb_tlb_lookup_second_chance
// self-checking bench for the second-chance tlb: a scoreboard keeps its own
// copy of the entry marks, predicts every translation and compares each
// result transfer field by field, under random stalls on both streams
// ----------------------------------------------------------------------------

class tlb_scoreboard;

    typedef struct packed {
        logic [tlbsc_pkg::ADDR_BITS-1:0] phys;
        logic                            hit;
        logic                            mark_dirty;
        logic                            ev_dirty;
        logic [tlbsc_pkg::VPN_BITS-1:0]  ev_page;
    } xlate_t;

    bit                              ent_valid [tlbsc_pkg::ENTRIES];
    bit                              ent_used  [tlbsc_pkg::ENTRIES];
    bit                              ent_dirty [tlbsc_pkg::ENTRIES];
    logic [tlbsc_pkg::VPN_BITS-1:0]  ent_page  [tlbsc_pkg::ENTRIES];
    logic [tlbsc_pkg::PFN_BITS-1:0]  ent_frame [tlbsc_pkg::ENTRIES];
    logic [tlbsc_pkg::SHIFT_BITS-1:0] shift;
    xlate_t                          pending_xlate [$];
    int                              errors;

    function new();
        for (int i = 0; i < tlbsc_pkg::ENTRIES; i++) begin
            ent_valid[i] = 0;
            ent_used[i]  = 0;
            ent_dirty[i] = 0;
            ent_page[i]  = '0;
            ent_frame[i] = '0;
        end
        shift  = tlbsc_pkg::SHIFT_RESET;
        errors = 0;
    endfunction

    function void note_access(logic [tlbsc_pkg::VPN_BITS-1:0] vpn,
                              logic [tlbsc_pkg::OFF_BITS-1:0] off,
                              logic wr,
                              logic [tlbsc_pkg::PFN_BITS-1:0] walk);
        int          slot;
        bit          found;
        bit          free_found;
        bit          clear_found;
        logic [63:0] off_m;
        logic [63:0] frame;
        xlate_t      r;
        slot        = 0;
        found       = 0;
        free_found  = 0;
        clear_found = 0;
        r           = '0;
        off_m       = 64'(off) & ((64'd1 << shift) - 64'd1);
        for (int i = 0; i < tlbsc_pkg::ENTRIES; i++) begin
            if (!found && ent_valid[i] && ent_page[i] == vpn) begin
                slot  = i;
                found = 1;
            end
        end
        if (found) begin
            ent_used[slot] = 1;
            if (wr) ent_dirty[slot] = 1;
            frame        = 64'(ent_frame[slot]);
            r.hit        = 1'b1;
            r.mark_dirty = wr;
        end else begin
            for (int i = 0; i < tlbsc_pkg::ENTRIES; i++) begin
                if (!free_found && !ent_valid[i]) begin
                    slot       = i;
                    free_found = 1;
                end
            end
            if (!free_found) begin
                // sweep from entry 0, clearing marks up to the first clear one
                for (int i = 0; i < tlbsc_pkg::ENTRIES; i++) begin
                    if (!clear_found) begin
                        if (!ent_used[i]) begin
                            slot        = i;
                            clear_found = 1;
                        end else begin
                            ent_used[i] = 0;
                        end
                    end
                end
                if (!clear_found) slot = 0;
                if (ent_dirty[slot]) begin
                    r.ev_dirty = 1'b1;
                    r.ev_page  = ent_page[slot];
                end
            end
            ent_page[slot]  = vpn;
            ent_frame[slot] = walk;
            ent_valid[slot] = 1;
            ent_used[slot]  = 1;
            ent_dirty[slot] = wr;
            frame           = 64'(walk);
        end
        r.phys = 32'((frame << shift) | off_m);
        pending_xlate.push_back(r);
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report($sformatf("%s got %h expected %h", name, got, want));
    endtask

    task check_result(logic [tlbsc_pkg::OUT_TDATA_BITS-1:0] t);
        xlate_t want;
        if (pending_xlate.size() == 0) begin
            report($sformatf("result %h with nothing pending", t));
        end else begin
            want = pending_xlate.pop_front();
            cmp_field("phys_addr", t[31:0], want.phys);
            cmp_field("hit", 32'(t[32]), 32'(want.hit));
            cmp_field("mark_page_dirty", 32'(t[33]), 32'(want.mark_dirty));
            cmp_field("evict_dirty", 32'(t[34]), 32'(want.ev_dirty));
            cmp_field("evicted_page", 32'(t[54:35]), 32'(want.ev_page));
        end
    endtask

endclass

module tb_tlb_lookup_second_chance;

    timeunit 1ns;
    timeprecision 1ps;

    import tlbsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 250;
    localparam int POOL_SIZE      = 24;

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_we      = 1'b0;
    logic [SHIFT_BITS-1:0]     i_cfg_wdata   = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // tdata, low bit up: virt_page, page_offset, walk_frame, zero fill
    logic [IN_TDATA_BITS-1:0]  s_axis_tdata  = '0;
    // tuser: is_write
    logic                      s_axis_tuser  = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // tdata, low bit up: phys_addr, hit, mark_page_dirty, evict_dirty,
    // evicted_page, zero fill
    logic [OUT_TDATA_BITS-1:0] m_axis_tdata;

    tlb_scoreboard sb;
    // set while both sides must run without idling
    bit  no_idle = 0;
    int  quiet_cycles = 0;
    logic [VPN_BITS-1:0] page_pool [POOL_SIZE];

    tlb_lookup_second_chance uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result side: check every transfer, then pick the next ready at random unless no_idle holds it high
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 13);
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_tlb_lookup_second_chance NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // present one access and hold it until the transfer; valid stays high
    // so back-to-back accesses need no extra assignment
    task send_access(logic [VPN_BITS-1:0] vpn, logic [OFF_BITS-1:0] off,
                     logic wr, logic [PFN_BITS-1:0] walk);
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_BITS - IN_FIELD_BITS){1'b0}}, walk, off, vpn};
        s_axis_tuser  <= wr;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_access(vpn, off, wr, walk);
    endtask

    // stop sending and let every pending result come out
    task drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_xlate.size() != 0) @(posedge i_clk);
        // every access yields a result, so the pipe is empty
        repeat (4) @(posedge i_clk);
    endtask

    // page_shift may only change while the block is idle
    task write_page_shift(logic [SHIFT_BITS-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.shift = value;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // mostly pages from a small pool so that hits, sweeps and dirty
    // evictions keep happening, some fully random pages as noise
    task random_phase(int count);
        logic [VPN_BITS-1:0] vpn;
        for (int p = 0; p < POOL_SIZE; p++)
            page_pool[p] = VPN_BITS'($urandom);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < 85)
                vpn = page_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                vpn = VPN_BITS'($urandom);
            send_access(vpn, OFF_BITS'($urandom), 1'($urandom),
                        PFN_BITS'($urandom));
            // mid-phase, one time in four, a hold-off until the scoreboard is empty
            if (n == count / 2 && $urandom_range(0, 3) == 0)
                drain_results();
        end
    endtask

    logic [SHIFT_BITS-1:0] shift_plan [8];

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset page_shift
        send_access(20'h00000, 16'hFFFF, 1'b0, 16'hFFFF);  // miss, fill entry 0
        send_access(20'hFFFFF, 16'h0000, 1'b1, 16'h0000);  // write miss, dirty fill
        send_access(20'h00000, 16'h0ABC, 1'b1, 16'h1234);  // write hit
        send_access(20'hFFFFF, 16'hF00F, 1'b0, 16'h4321);  // read hit
        for (int i = 2; i < ENTRIES; i++)
            send_access(VPN_BITS'(100 + i), OFF_BITS'($urandom), 1'(i),
                        PFN_BITS'($urandom));
        // table full with every mark set: sweep clears all, entry 0 replaced
        send_access(20'h55555, 16'h5A5A, 1'b0, 16'hAAAA);
        // entry 1 now clear and dirty: dirty eviction of the top page
        send_access(20'hAAAAA, 16'hA5A5, 1'b1, 16'h5555);
        send_access(20'd102, 16'h0001, 1'b0, 16'h0000);     // hit on a cleared mark
        // entry 0 already has a clear mark, so its clean page 55555 is the victim
        send_access(20'h12345, 16'h8000, 1'b0, 16'hFFFF);
        drain_results();

        // extremes first, then values beyond the usual range, then the reset value, random values and 4 again
        shift_plan[0] = 5'd4;
        shift_plan[1] = 5'd16;
        shift_plan[2] = 5'd31;
        shift_plan[3] = 5'd0;
        shift_plan[4] = SHIFT_RESET;
        shift_plan[5] = SHIFT_BITS'($urandom_range(0, 31));
        shift_plan[6] = SHIFT_BITS'($urandom_range(4, 16));
        shift_plan[7] = 5'd4;
        for (int ph = 0; ph < 8; ph++) begin
            write_page_shift(shift_plan[ph]);
            no_idle = (ph == 2);
            random_phase(PHASE_ITEMS);
            if (ph == 1) drain_results();
            no_idle = 0;
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_tlb_lookup_second_chance OK");
        else
            $display("tb_tlb_lookup_second_chance NOT OK");
        $finish;
    end

endmodule
